/* hdl/polar_gaussian_sample_pair_defines.svh */
// Assertion macros for the polar Gaussian sample pair block.
// Used by the top level; relies on clk and rst_n in the including scope.
`ifndef POLAR_GAUSSIAN_SAMPLE_PAIR_DEFINES_SVH
`define POLAR_GAUSSIAN_SAMPLE_PAIR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PGSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, checked out of reset
`define PGSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* hdl/pgsp_pkg.sv */
// Package for the polar Gaussian sample pair block: constants and stage types.
// No dependencies; used by pgsp_mult_pipe and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pgsp_pkg;

  // fraction bits of the multiplier m and of the scaled samples
  localparam int FRAC_BITS = 24;
  // pipeline depths of the iterative units
  localparam int LOG_STEPS   = 32;  // one squaring per stage
  localparam int DIV_STAGES  = 32;  // two quotient bits per stage
  localparam int SQRT_STAGES = 16;  // two root bits per stage
  localparam int SHIFT_OFS   = FRAC_BITS - 28;

  localparam logic [30:0] HALF_RANGE  = 31'h3FFF_FFFF;
  localparam logic [31:0] TWO_LN2_Q31 = 32'd2977044472;

  typedef enum logic {
    CFG_SIGMA = 1'b0,
    CFG_MEAN  = 1'b1
  } cfg_idx_t;

  // per-coordinate sign and magnitude, index 0 is a, index 1 is b
  typedef struct packed {
    logic [1:0]       sign;
    logic [1:0][30:0] mag;
  } tag_t;

  // normalized rsq = f * 2^-k handed to the multiplier pipeline
  typedef struct packed {
    logic        valid;
    logic [5:0]  k;
    logic [31:0] f;
    tag_t        tag;
  } norm_t;

  // multiplier m in Q FRAC_BITS
  typedef struct packed {
    logic        valid;
    logic [63:0] m;
    tag_t        tag;
  } mult_t;

endpackage

`default_nettype wire

/* hdl/pgsp_mult_pipe.sv */
// Pipelined m = sqrt(-2 ln(rsq) / rsq): log2 by squaring, long division, isqrt.
// Depends on pgsp_pkg. 84 register stages, one item per cycle while en is high (global enable).
`timescale 1ns / 1ps
`default_nettype none

module pgsp_mult_pipe (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire pgsp_pkg::norm_t in_item,
  output pgsp_pkg::mult_t      out_item
);

  typedef struct packed {
    logic             valid;
    logic [5:0]       k;
    logic [31:0]      f;
    logic [31:0]      x;
    logic [31:0]      lg;
    pgsp_pkg::tag_t   tag;
  } log_t;

  typedef struct packed {
    logic             valid;
    logic [5:0]       k;
    logic [31:0]      f;
    logic [5:0]       th;
    logic [31:0]      tl;
    pgsp_pkg::tag_t   tag;
  } tsub_t;

  typedef struct packed {
    logic             valid;
    logic [5:0]       k;
    logic [31:0]      f;
    logic [38:0]      ph;
    logic [32:0]      pl;
    pgsp_pkg::tag_t   tag;
  } prod_t;

  typedef struct packed {
    logic             valid;
    logic [5:0]       k;
    logic [31:0]      f;
    logic [39:0]      n;
    pgsp_pkg::tag_t   tag;
  } nsum_t;

  typedef struct packed {
    logic             valid;
    logic [5:0]       k;
    logic [31:0]      f;
    logic [31:0]      rem;
    logic [7:0]       nbits;
    logic [63:0]      q;
    pgsp_pkg::tag_t   tag;
  } div_t;

  typedef struct packed {
    logic             valid;
    logic [5:0]       k;
    logic [63:0]      rad;
    logic [33:0]      rem;
    logic [31:0]      root;
    pgsp_pkg::tag_t   tag;
  } sqrt_t;

  log_t  log_in;
  log_t  log_r   [pgsp_pkg::LOG_STEPS];
  log_t  log_nxt [pgsp_pkg::LOG_STEPS];
  tsub_t t_r, t_nxt;
  prod_t p_r, p_nxt;
  nsum_t n_r, n_nxt;
  div_t  div_in;
  div_t  div_r   [pgsp_pkg::DIV_STAGES];
  div_t  div_nxt [pgsp_pkg::DIV_STAGES];
  sqrt_t sqrt_in;
  sqrt_t sqrt_r   [pgsp_pkg::SQRT_STAGES];
  sqrt_t sqrt_nxt [pgsp_pkg::SQRT_STAGES];
  pgsp_pkg::mult_t out_r, out_nxt;

  logic [37:0] tt;
  logic [63:0] pl_full;
  logic [7:0]  e;
  logic [7:0]  ne;

  // log2(f) in Q32: square, renormalize, emit one bit per stage
  always_comb begin
    log_in.valid = in_item.valid;
    log_in.k     = in_item.k;
    log_in.f     = in_item.f;
    log_in.x     = in_item.f;
    log_in.lg    = 32'd0;
    log_in.tag   = in_item.tag;
  end

  for (genvar i = 0; i < pgsp_pkg::LOG_STEPS; i++) begin : g_log
    log_t        src;
    log_t        cur;
    logic [63:0] sq;
    logic [32:0] xs;

    if (i == 0) begin : g_first
      assign src = log_in;
    end else begin : g_next
      assign src = log_r[i-1];
    end

    always_comb begin
      cur = src;
      sq  = {32'b0, src.x} * {32'b0, src.x};
      xs  = sq[63:31];
      if (xs[32]) begin
        cur.x = xs[32:1];
        cur.lg[pgsp_pkg::LOG_STEPS-1-i] = 1'b1;
      end else begin
        cur.x = xs[31:0];
      end
      log_nxt[i] = cur;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        log_r[i].valid <= 1'b0;
      end else if (en) begin
        log_r[i] <= log_nxt[i];
      end
    end
  end

  // T = k*2^32 - lg, then N = T * 2ln2, then the sum
  always_comb begin
    tt          = {log_r[pgsp_pkg::LOG_STEPS-1].k, 32'b0} -
                  {6'b0, log_r[pgsp_pkg::LOG_STEPS-1].lg};
    t_nxt.valid = log_r[pgsp_pkg::LOG_STEPS-1].valid;
    t_nxt.k     = log_r[pgsp_pkg::LOG_STEPS-1].k;
    t_nxt.f     = log_r[pgsp_pkg::LOG_STEPS-1].f;
    t_nxt.th    = tt[37:32];
    t_nxt.tl    = tt[31:0];
    t_nxt.tag   = log_r[pgsp_pkg::LOG_STEPS-1].tag;
  end

  always_comb begin
    pl_full     = {32'b0, t_r.tl} * {32'b0, pgsp_pkg::TWO_LN2_Q31};
    p_nxt.valid = t_r.valid;
    p_nxt.k     = t_r.k;
    p_nxt.f     = t_r.f;
    p_nxt.ph    = {32'b0, t_r.th, 1'b0} * {7'b0, pgsp_pkg::TWO_LN2_Q31};
    p_nxt.pl    = pl_full[63:31];
    p_nxt.tag   = t_r.tag;
  end

  always_comb begin
    n_nxt.valid = p_r.valid;
    n_nxt.k     = p_r.k;
    n_nxt.f     = p_r.f;
    n_nxt.n     = {1'b0, p_r.ph} + {7'b0, p_r.pl};
    n_nxt.tag   = p_r.tag;
  end

  // q = floor(N * 2^56 / f), restoring division, two bits per stage
  always_comb begin
    div_in.valid = n_r.valid;
    div_in.k     = n_r.k;
    div_in.f     = n_r.f;
    div_in.rem   = n_r.n[39:8];
    div_in.nbits = n_r.n[7:0];
    div_in.q     = 64'd0;
    div_in.tag   = n_r.tag;
  end

  for (genvar i = 0; i < pgsp_pkg::DIV_STAGES; i++) begin : g_div
    div_t        src;
    div_t        cur;
    logic [32:0] r2;

    if (i == 0) begin : g_first
      assign src = div_in;
    end else begin : g_next
      assign src = div_r[i-1];
    end

    always_comb begin
      cur = src;
      r2  = 33'd0;
      for (int s = 0; s < 2; s++) begin
        r2        = {cur.rem, cur.nbits[7]};
        cur.nbits = {cur.nbits[6:0], 1'b0};
        if (r2 >= {1'b0, cur.f}) begin
          r2    = r2 - {1'b0, cur.f};
          cur.q = {cur.q[62:0], 1'b1};
        end else begin
          cur.q = {cur.q[62:0], 1'b0};
        end
        cur.rem = r2[31:0];
      end
      div_nxt[i] = cur;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_r[i].valid <= 1'b0;
      end else if (en) begin
        div_r[i] <= div_nxt[i];
      end
    end
  end

  // floor(sqrt(q)), halved first when k is even, two root bits per stage
  always_comb begin
    sqrt_in.valid = div_r[pgsp_pkg::DIV_STAGES-1].valid;
    sqrt_in.k     = div_r[pgsp_pkg::DIV_STAGES-1].k;
    sqrt_in.rad   = div_r[pgsp_pkg::DIV_STAGES-1].k[0] ?
                    div_r[pgsp_pkg::DIV_STAGES-1].q :
                    {1'b0, div_r[pgsp_pkg::DIV_STAGES-1].q[63:1]};
    sqrt_in.rem   = 34'd0;
    sqrt_in.root  = 32'd0;
    sqrt_in.tag   = div_r[pgsp_pkg::DIV_STAGES-1].tag;
  end

  for (genvar i = 0; i < pgsp_pkg::SQRT_STAGES; i++) begin : g_sqrt
    sqrt_t       src;
    sqrt_t       cur;
    logic [35:0] rem2;
    logic [35:0] trial;

    if (i == 0) begin : g_first
      assign src = sqrt_in;
    end else begin : g_next
      assign src = sqrt_r[i-1];
    end

    always_comb begin
      cur   = src;
      rem2  = 36'd0;
      trial = 36'd0;
      for (int s = 0; s < 2; s++) begin
        rem2    = {cur.rem, cur.rad[63:62]};
        cur.rad = {cur.rad[61:0], 2'b0};
        trial   = {2'b0, cur.root, 2'b01};
        if (rem2 >= trial) begin
          rem2     = rem2 - trial;
          cur.root = {cur.root[30:0], 1'b1};
        end else begin
          cur.root = {cur.root[30:0], 1'b0};
        end
        cur.rem = rem2[33:0];
      end
      sqrt_nxt[i] = cur;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sqrt_r[i].valid <= 1'b0;
      end else if (en) begin
        sqrt_r[i] <= sqrt_nxt[i];
      end
    end
  end

  // scale the root into Q FRAC_BITS by 2^((k>>1) + FRAC_BITS - 28)
  always_comb begin
    e             = {3'b0, sqrt_r[pgsp_pkg::SQRT_STAGES-1].k[5:1]} +
                    8'(pgsp_pkg::SHIFT_OFS);
    ne            = 8'd0 - e;
    out_nxt.valid = sqrt_r[pgsp_pkg::SQRT_STAGES-1].valid;
    out_nxt.tag   = sqrt_r[pgsp_pkg::SQRT_STAGES-1].tag;
    if (e[7]) begin
      out_nxt.m = {32'b0, sqrt_r[pgsp_pkg::SQRT_STAGES-1].root} >> ne;
    end else begin
      out_nxt.m = {32'b0, sqrt_r[pgsp_pkg::SQRT_STAGES-1].root} << e;
    end
  end

  // single-stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r.valid   <= 1'b0;
      p_r.valid   <= 1'b0;
      n_r.valid   <= 1'b0;
      out_r.valid <= 1'b0;
    end else if (en) begin
      t_r   <= t_nxt;
      p_r   <= p_nxt;
      n_r   <= n_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_item = out_r;

endmodule

`default_nettype wire

/* hdl/polar_gaussian_sample_pair.sv */
// Polar Box-Muller transform: uniform pair in, two Gaussian samples out.
// Throughput: a new pair every cycle into the 95-stage pipeline while in_ready is high; the
// output register sends one sample per cycle while out_ready is high. The pipeline stalls
// only while its last stage holds an accepted pair that the output register cannot yet take.
// Reset (rst_n, synchronous): empties the pipeline, sigma = 1, mean = 0.
// Depends on pgsp_pkg, pgsp_mult_pipe and polar_gaussian_sample_pair_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "polar_gaussian_sample_pair_defines.svh"

module polar_gaussian_sample_pair (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [30:0]        in_uniform_a,
  input  wire logic [30:0]        in_uniform_b,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_sample,
  output logic                    out_last,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data
);

  typedef struct packed {
    logic           valid;
    pgsp_pkg::tag_t tag;
  } c1_t;

  typedef struct packed {
    logic             valid;
    pgsp_pkg::tag_t   tag;
    logic [1:0][61:0] sq;
  } c2_t;

  typedef struct packed {
    logic           valid;
    pgsp_pkg::tag_t tag;
    logic [59:0]    rsq;
  } c3_t;

  typedef struct packed {
    logic           valid;
    pgsp_pkg::tag_t tag;
    logic [59:0]    rsq;
    logic [5:0]     lz;
  } c4_t;

  typedef struct packed {
    logic             valid;
    logic [1:0]       sign;
    logic [1:0][62:0] ph;
    logic [1:0][62:0] pl;
  } amp_t;

  typedef struct packed {
    logic             valid;
    logic [1:0]       sign;
    logic [1:0][63:0] am;
  } am_t;

  typedef struct packed {
    logic             valid;
    logic [1:0]       sign;
    logic [1:0][47:0] sl;
    logic [1:0][31:0] sh;
  } sgp_t;

  typedef struct packed {
    logic             valid;
    logic [1:0]       sign;
    logic [1:0][63:0] scaled;
  } sc_t;

  typedef struct packed {
    logic             valid;
    logic [1:0][63:0] val;
  } v_t;

  typedef enum logic [1:0] {
    SER_EMPTY,
    SER_FIRST,
    SER_SECOND
  } ser_state_t;

  c1_t  c1_r, c1_nxt;
  c2_t  c2_r, c2_nxt;
  c3_t  c3_r, c3_nxt;
  c4_t  c4_r, c4_nxt;
  pgsp_pkg::norm_t norm_r, norm_nxt;
  pgsp_pkg::mult_t mult_out;
  amp_t amp_r, amp_nxt;
  am_t  am_r, am_nxt;
  sgp_t sgp_r, sgp_nxt;
  sc_t  sc_r, sc_nxt;
  v_t   v_r, v_nxt;
  v_t   r_r, r_nxt;

  logic [15:0]      sigma_r;
  logic [15:0]      mean_r;
  ser_state_t       state_r;
  logic [31:0]      smp_a_r;
  logic [31:0]      smp_b_r;
  logic             ser_free;
  logic             adv;
  logic [62:0]      rsq_sum;
  logic [59:0]      norm_sh;
  logic [63:0]      base;
  logic [63:0]      nv;
  logic [1:0][31:0] sat;

  // a = trunc((u - H) * 2^30 / H) with H = 2^30-1: |a| = |d| + (|d| >= H)
  function automatic logic [31:0] coord_of(input logic [30:0] u);
    logic [31:0] d;
    logic [31:0] nd;
    logic [30:0] x;
    d  = {1'b0, u} - {1'b0, pgsp_pkg::HALF_RANGE};
    nd = 32'd0 - d;
    x  = d[31] ? nd[30:0] : d[30:0];
    return {d[31], x + {30'b0, (x >= pgsp_pkg::HALF_RANGE)}};
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r <= 16'd1;
      mean_r  <= 16'd0;
    end else if (cfg_we) begin
      unique case (pgsp_pkg::cfg_idx_t'(cfg_index))
        pgsp_pkg::CFG_SIGMA: sigma_r <= cfg_data;
        pgsp_pkg::CFG_MEAN:  mean_r  <= cfg_data;
        default:             sigma_r <= sigma_r;
      endcase
    end
  end

  // whole pipeline moves unless the last stage is full and the output can't take it
  assign ser_free = (state_r == SER_EMPTY) || ((state_r == SER_SECOND) && out_ready);
  assign adv      = !r_r.valid || ser_free;
  assign in_ready = adv;

  // front end: coordinates, squares, rsq with rejection, normalization
  always_comb begin
    logic [31:0] ca;
    logic [31:0] cb;
    ca                 = coord_of(in_uniform_a);
    cb                 = coord_of(in_uniform_b);
    c1_nxt.valid       = in_valid;
    c1_nxt.tag.sign    = {cb[31], ca[31]};
    c1_nxt.tag.mag[0]  = ca[30:0];
    c1_nxt.tag.mag[1]  = cb[30:0];
  end

  always_comb begin
    c2_nxt.valid = c1_r.valid;
    c2_nxt.tag   = c1_r.tag;
    for (int c = 0; c < 2; c++) begin
      c2_nxt.sq[c] = {31'b0, c1_r.tag.mag[c]} * {31'b0, c1_r.tag.mag[c]};
    end
  end

  always_comb begin
    rsq_sum      = {1'b0, c2_r.sq[0]} + {1'b0, c2_r.sq[1]};
    c3_nxt.valid = c2_r.valid && (rsq_sum != 63'd0) && (rsq_sum[62:60] == 3'd0);
    c3_nxt.tag   = c2_r.tag;
    c3_nxt.rsq   = rsq_sum[59:0];
  end

  // leading zeros of rsq in 60 bits
  always_comb begin
    c4_nxt.valid = c3_r.valid;
    c4_nxt.tag   = c3_r.tag;
    c4_nxt.rsq   = c3_r.rsq;
    c4_nxt.lz    = 6'd0;
    for (int i = 0; i < 60; i++) begin
      if (c3_r.rsq[i]) begin
        c4_nxt.lz = 6'(59 - i);
      end
    end
  end

  always_comb begin
    norm_sh        = c4_r.rsq << c4_r.lz;
    norm_nxt.valid = c4_r.valid;
    norm_nxt.k     = c4_r.lz + 6'd1;
    norm_nxt.f     = norm_sh[59:28];
    norm_nxt.tag   = c4_r.tag;
  end

  pgsp_mult_pipe u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_item  (norm_r),
    .out_item (mult_out)
  );

  // back end: |a|*m, sigma scaling, mean offset, truncation, saturation
  always_comb begin
    amp_nxt.valid = mult_out.valid;
    amp_nxt.sign  = mult_out.tag.sign;
    for (int c = 0; c < 2; c++) begin
      amp_nxt.ph[c] = {32'b0, mult_out.tag.mag[c]} * {31'b0, mult_out.m[63:32]};
      amp_nxt.pl[c] = {32'b0, mult_out.tag.mag[c]} * {31'b0, mult_out.m[31:0]};
    end
  end

  always_comb begin
    am_nxt.valid = amp_r.valid;
    am_nxt.sign  = amp_r.sign;
    for (int c = 0; c < 2; c++) begin
      am_nxt.am[c] = {amp_r.ph[c][61:0], 2'b0} + {31'b0, amp_r.pl[c][62:30]};
    end
  end

  always_comb begin
    sgp_nxt.valid = am_r.valid;
    sgp_nxt.sign  = am_r.sign;
    for (int c = 0; c < 2; c++) begin
      sgp_nxt.sl[c] = {16'b0, am_r.am[c][31:0]} * {32'b0, sigma_r};
      sgp_nxt.sh[c] = am_r.am[c][63:32] * {16'b0, sigma_r};
    end
  end

  always_comb begin
    sc_nxt.valid = sgp_r.valid;
    sc_nxt.sign  = sgp_r.sign;
    for (int c = 0; c < 2; c++) begin
      sc_nxt.scaled[c] = {16'b0, sgp_r.sl[c]} + {sgp_r.sh[c], 32'b0};
    end
  end

  always_comb begin
    base        = {{48{mean_r[15]}}, mean_r} << pgsp_pkg::FRAC_BITS;
    v_nxt.valid = sc_r.valid;
    for (int c = 0; c < 2; c++) begin
      v_nxt.val[c] = sc_r.sign[c] ? base - sc_r.scaled[c] : base + sc_r.scaled[c];
    end
  end

  // shift toward zero
  always_comb begin
    nv          = 64'd0;
    r_nxt.valid = v_r.valid;
    for (int c = 0; c < 2; c++) begin
      if (!v_r.val[c][63]) begin
        r_nxt.val[c] = $signed(v_r.val[c]) >>> pgsp_pkg::FRAC_BITS;
      end else begin
        nv           = 64'd0 - v_r.val[c];
        r_nxt.val[c] = 64'd0 - ($signed(nv) >>> pgsp_pkg::FRAC_BITS);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      if (r_r.val[c][63:31] == {33{r_r.val[c][63]}}) begin
        sat[c] = r_r.val[c][31:0];
      end else begin
        sat[c] = r_r.val[c][63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
    end
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r.valid   <= 1'b0;
      c2_r.valid   <= 1'b0;
      c3_r.valid   <= 1'b0;
      c4_r.valid   <= 1'b0;
      norm_r.valid <= 1'b0;
      amp_r.valid  <= 1'b0;
      am_r.valid   <= 1'b0;
      sgp_r.valid  <= 1'b0;
      sc_r.valid   <= 1'b0;
      v_r.valid    <= 1'b0;
      r_r.valid    <= 1'b0;
    end else if (adv) begin
      c1_r   <= c1_nxt;
      c2_r   <= c2_nxt;
      c3_r   <= c3_nxt;
      c4_r   <= c4_nxt;
      norm_r <= norm_nxt;
      amp_r  <= amp_nxt;
      am_r   <= am_nxt;
      sgp_r  <= sgp_nxt;
      sc_r   <= sc_nxt;
      v_r    <= v_nxt;
      r_r    <= r_nxt;
    end
  end

  // output register: sends sample a, then sample b marked last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SER_EMPTY;
    end else if (adv && r_r.valid) begin
      state_r <= SER_FIRST;
      smp_a_r <= sat[0];
      smp_b_r <= sat[1];
    end else begin
      unique case (state_r)
        SER_EMPTY:  state_r <= SER_EMPTY;
        SER_FIRST:  if (out_ready) state_r <= SER_SECOND;
        SER_SECOND: if (out_ready) state_r <= SER_EMPTY;
        default:    state_r <= SER_EMPTY;
      endcase
    end
  end

  assign out_valid  = (state_r != SER_EMPTY);
  assign out_last   = (state_r == SER_SECOND);
  assign out_sample = (state_r == SER_SECOND) ? smp_b_r : smp_a_r;

  // checks
  `PGSP_ASSERT_NXT(a_pair_order, out_valid && !out_last && out_ready, out_valid && out_last)
  `PGSP_ASSERT_NXT(a_stall_holds, !adv, r_r.valid == $past(r_r.valid))
  `PGSP_ASSERT_IMP(a_rsq_nonzero, c4_r.valid, c4_r.rsq != 60'd0)

endmodule

`default_nettype wire

/* sim/tb_polar_gaussian_sample_pair.sv */
// Testbench for polar_gaussian_sample_pair: uniform pairs in, checked Gaussian samples out.
// Self-contained; needs only pgsp_pkg and the block's RTL. A scoreboard class predicts
// each accepted pair's samples in fixed point and compares them in order.
`timescale 1ns / 1ps

// Expected-sample store with its own fixed-point Gaussian transform
class gauss_scoreboard;
  typedef struct {
    logic signed [31:0] sample;
    logic               last;
  } gauss_sample_t;

  localparam longint HALF = 64'd1073741823;

  gauss_sample_t exp_samples[$];
  logic [15:0]   sigma;
  int            mean;
  int            errors;
  int            checked;
  int            accepted_pairs;
  int            rejected_pairs;

  function new();
    sigma  = 16'd1;
    mean   = 0;
    errors = 0;
  endfunction

  function void set_reg(pgsp_pkg::cfg_idx_t idx, logic [15:0] data);
    if (idx == pgsp_pkg::CFG_SIGMA) sigma = data;
    else mean = int'($signed(data));
  endfunction

  // point coordinate in Q30, truncated toward zero
  function longint coord(logic [30:0] u);
    longint d;
    d = longint'({33'd0, u}) - HALF;
    return (d <<< 30) / HALF;
  endfunction

  function logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // m = sqrt(-2 ln(rsq) / rsq) in Q FRAC_BITS, for 0 < rsq < 1 (Q60)
  function logic [63:0] radial_mult(logic [63:0] rsq);
    int          p, k, e;
    logic [63:0] f, x, lg, t, n, q, r, s;
    p  = 0;
    lg = 0;
    for (int i = 0; i < 60; i++)
      if (rsq[i]) p = i;
    k = 60 - p;
    f = (p >= 31) ? (rsq >> (p - 31)) : (rsq << (31 - p));
    // log2 of the mantissa by repeated squaring
    x = f;
    for (int i = 0; i < 32; i++) begin
      x = (x * x) >> 31;
      if (x >> 32) begin
        x  = x >> 1;
        lg = lg | (64'd1 << (31 - i));
      end
    end
    t = (64'(k) << 32) - lg;
    n = (t >> 32) * 64'(pgsp_pkg::TWO_LN2_Q31) * 64'd2
        + (((t & 64'hFFFF_FFFF) * 64'(pgsp_pkg::TWO_LN2_Q31)) >> 31);
    // long division to Q56
    q = n / f;
    r = n % f;
    for (int i = 0; i < 56; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= f) begin
        r = r - f;
        q = q | 64'd1;
      end
    end
    if ((k & 1) == 0) q = q >> 1;
    s = isqrt(q);
    e = (k >> 1) + pgsp_pkg::FRAC_BITS - 28;
    return (e >= 0) ? (s << e) : (s >> (-e));
  endfunction

  function logic [31:0] scaled_sample(longint a, logic [63:0] m);
    logic [63:0] mag, am;
    longint      scaled, v, r;
    mag    = (a < 0) ? -a : a;
    am     = ((mag * (m >> 32)) << 2) + ((mag * (m & 64'hFFFF_FFFF)) >> 30);
    scaled = longint'(64'(sigma) * am);
    v      = longint'(mean) <<< pgsp_pkg::FRAC_BITS;
    v      = (a < 0) ? v - scaled : v + scaled;
    r      = (v >= 0) ? (v >>> pgsp_pkg::FRAC_BITS) : -((-v) >>> pgsp_pkg::FRAC_BITS);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  // called on each input transfer
  function void note_pair(logic [30:0] ua, logic [30:0] ub);
    longint        a, b;
    logic [63:0]   rsq, m;
    gauss_sample_t item;
    a   = coord(ua);
    b   = coord(ub);
    rsq = 64'(a * a) + 64'(b * b);
    if (rsq == 0 || rsq >= (64'd1 << 60)) begin
      rejected_pairs++;
      return;
    end
    accepted_pairs++;
    m           = radial_mult(rsq);
    item.sample = scaled_sample(a, m);
    item.last   = 1'b0;
    exp_samples.push_back(item);
    item.sample = scaled_sample(b, m);
    item.last   = 1'b1;
    exp_samples.push_back(item);
  endfunction

  function void report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endfunction

  // called on each output transfer
  function void check_sample(logic signed [31:0] sample, logic last);
    gauss_sample_t item;
    checked++;
    if (exp_samples.size() == 0) begin
      report($sformatf("unexpected sample %0d last=%0b", sample, last));
      return;
    end
    item = exp_samples.pop_front();
    if (sample !== item.sample)
      report($sformatf("sample %0d, expected %0d", sample, item.sample));
    if (last !== item.last)
      report($sformatf("last %0b, expected %0b", last, item.last));
  endfunction

  function int pending();
    return exp_samples.size();
  endfunction
endclass

module tb_polar_gaussian_sample_pair;

  localparam int     LIMIT_CYCLES = 300000;
  localparam int     DRAIN_CYCLES = 110;
  localparam logic [30:0] CENTER  = 31'h3FFF_FFFF;
  localparam logic [30:0] TOP     = 31'h7FFF_FFFF;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [30:0]        in_uniform_a;
  logic [30:0]        in_uniform_b;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_sample;
  logic               out_last;
  logic               cfg_we;
  logic               cfg_index;
  logic [15:0]        cfg_data;

  gauss_scoreboard sb;
  int  snd_idle;
  int  rcv_idle;
  bit  hold_off;
  int  cycles;

  polar_gaussian_sample_pair u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_uniform_a (in_uniform_a),
    .in_uniform_b (in_uniform_b),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sample   (out_sample),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // cycle count and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d samples pending", cycles, sb.pending());
      $display("** polar_gaussian_sample_pair: FAILED **");
      $finish;
    end
  end

  // receiver readiness
  always @(negedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= rcv_idle);
  end

  // output transfer check
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_sample(out_sample, out_last);
  end

  task automatic send_pair(logic [30:0] ua, logic [30:0] ub);
    while ($urandom_range(99) < snd_idle) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_uniform_a <= ua;
    in_uniform_b <= ub;
    do @(posedge clk); while (!in_ready);
    sb.note_pair(ua, ub);
  endtask

  // register write once the pipeline has drained
  task automatic write_reg(pgsp_pkg::cfg_idx_t idx, logic [15:0] data);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  function automatic logic [30:0] rand_uniform();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return 31'($urandom);
    if (sel < 90) return CENTER + 31'($urandom_range(2000)) - 31'd1000;
    if (sel < 95) return 31'($urandom_range(3));
    return TOP - 31'($urandom_range(3));
  endfunction

  task automatic random_pairs(int count);
    for (int i = 0; i < count; i++) send_pair(rand_uniform(), rand_uniform());
  endtask

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_uniform_a = '0;
    in_uniform_b = '0;
    out_ready    = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = pgsp_pkg::CFG_SIGMA;
    cfg_data     = '0;
    hold_off     = 1'b0;
    cycles       = 0;
    snd_idle     = 14;
    rcv_idle     = 67;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: rejections, tiny and near-unit radius, extremes, bit patterns
    send_pair(31'd0, 31'd0);
    send_pair(CENTER, CENTER);
    send_pair(TOP, TOP);
    send_pair(31'd0, CENTER);
    send_pair(CENTER, TOP - 31'd1);
    send_pair(CENTER + 31'd1, CENTER);
    send_pair(CENTER, CENTER + 31'd1);
    send_pair(CENTER - 31'd1, CENTER);
    send_pair(CENTER, CENTER - 31'd1);
    send_pair(31'd1, CENTER);
    send_pair(CENTER, 31'd1);
    send_pair(TOP - 31'd2, CENTER);
    send_pair(31'h5555_5555, 31'h2AAA_AAAA);
    send_pair(31'h2AAA_AAAA, 31'h5555_5555);
    send_pair(31'h3000_0000, 31'h5000_0000);
    send_pair(31'h1800_0000, 31'h3FFF_0000);
    send_pair(CENTER + 31'd1000, CENTER - 31'd700);
    write_reg(pgsp_pkg::CFG_SIGMA, 16'hFFFF);
    write_reg(pgsp_pkg::CFG_MEAN, 16'h8000);
    send_pair(CENTER + 31'd1, CENTER);
    send_pair(CENTER, CENTER - 31'd1);
    send_pair(31'd1, CENTER);
    send_pair(31'h3000_0000, 31'h5000_0000);
    write_reg(pgsp_pkg::CFG_SIGMA, 16'd1);
    write_reg(pgsp_pkg::CFG_MEAN, 16'd0);
    random_pairs(200);

    // swapped idling, widest scale and most negative offset
    write_reg(pgsp_pkg::CFG_SIGMA, 16'hFFFF);
    write_reg(pgsp_pkg::CFG_MEAN, 16'h8000);
    snd_idle = 67;
    rcv_idle = 14;
    random_pairs(200);

    // no idling, zero scale and most positive offset; long receiver hold-off
    write_reg(pgsp_pkg::CFG_SIGMA, 16'd0);
    write_reg(pgsp_pkg::CFG_MEAN, 16'h7FFF);
    snd_idle = 0;
    rcv_idle = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    random_pairs(200);

    // random settings
    write_reg(pgsp_pkg::CFG_SIGMA, 16'($urandom));
    write_reg(pgsp_pkg::CFG_MEAN, 16'($urandom));
    random_pairs(100);
    write_reg(pgsp_pkg::CFG_SIGMA, 16'($urandom_range(300)));
    write_reg(pgsp_pkg::CFG_MEAN, 16'($urandom));
    random_pairs(100);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("pairs sent: %0d accepted by the transform, %0d rejected; %0d samples checked",
             sb.accepted_pairs, sb.rejected_pairs, sb.checked);
    $display("covered sigma/mean extremes, random settings, stalls and a long output hold-off");
    if (sb.errors == 0) begin
      $display("** polar_gaussian_sample_pair: PASSED **");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("** polar_gaussian_sample_pair: FAILED **");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+hdl
hdl/pgsp_pkg.sv
hdl/pgsp_mult_pipe.sv
hdl/polar_gaussian_sample_pair.sv
sim/tb_polar_gaussian_sample_pair.sv
